/* design/raf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package raf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int COORD_W    = 10;
  localparam int PIXEL_W    = 16;
  localparam int RECT_W     = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FILL_RED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_GREEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_BLUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM = 3'd7;

  localparam logic [7:0] FULL_SCALE         = 8'd255;
  localparam logic [7:0] DEST_WEIGHT_RESET  = 8'd200;

  // Load enables of the stages behind the first one.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

  // Pixel data that rides along the pipeline.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] px;
    logic               in_rect;
  } pix_t;

  // Exact floor(x / 255) for 0 <= x <= 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // floor(c * 255 / 31): 255 = 8 * 31 + 7, and floor(7c / 31) = (7c * 265) >> 13 here.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [7:0]  y;
    logic [15:0] p;
    y = {c, 3'b000} - {3'b000, c};
    p = {8'd0, y} * 16'd265;
    return {c, 3'b000} + {5'd0, p[15:13]};
  endfunction

  // floor(c * 255 / 63): 255 = 4 * 63 + 3, and floor(3c / 63) = floor(c / 21) = (c * 49) >> 10.
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [11:0] p;
    p = {6'd0, c} * 12'd49;
    return {c, 2'b00} + {6'd0, p[11:10]};
  endfunction

endpackage

`default_nettype wire

/* design/raf_channel.sv */
`timescale 1ns / 1ps
`default_nettype none

module raf_channel #(
  parameter int CHAN_W = 5
) (
  input  wire logic              clk,
  input  wire raf_pkg::adv_t     adv,
  input  wire logic [7:0]        e8,
  input  wire logic [7:0]        fill,
  input  wire logic [7:0]        weight,
  output logic      [CHAN_W-1:0] code
);

  localparam logic [15:0] CHAN_MAX = 16'((1 << CHAN_W) - 1);

  logic [7:0]        inv_weight;
  logic [15:0]       sum_nxt;
  logic [15:0]       sum_r;
  logic [7:0]        blend_r;
  logic [15:0]       scaled;
  logic [7:0]        quot;
  logic [CHAN_W-1:0] code_r;

  assign inv_weight = raf_pkg::FULL_SCALE - weight;
  assign sum_nxt    = ({8'd0, fill} * {8'd0, inv_weight}) + ({8'd0, e8} * {8'd0, weight});
  assign scaled     = {8'd0, blend_r} * CHAN_MAX;
  assign quot       = raf_pkg::div255(scaled);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sum_r <= sum_nxt;
    end
    if (adv.s3) begin
      blend_r <= raf_pkg::div255(sum_r);
    end
    if (adv.s4) begin
      code_r <= quot[CHAN_W-1:0];
    end
  end

  assign code = code_r;

endmodule

`default_nettype wire

/* design/rgb565_inverse_alpha_fill.sv */
`timescale 1ns / 1ps
`default_nettype none

// Rectangle fill with alpha blend on an RGB565 pixel stream. One word enters per clock
// while in_stall is low, and its result passes through four register stages
// (rectangle test and channel expansion, weighted sum, scale by 1/255, scale back to the
// field width); the last stage is the output register. A pixel whose column lies in
// [rect_left, rect_right) and below FB_WIDTH and whose row lies in [rect_top, rect_bottom)
// and below FB_HEIGHT is blended as (fill*(255-dest_weight) + dest*dest_weight)/255 per
// channel; all other pixels pass through with out_inside_rect low. out_stall holds the
// output stage, and a stage behind it keeps loading while any stage ahead is empty, so
// in_stall rises only when all four stages are full and out_stall is high. Write the
// registers only while no word is in flight; cfg_ready is always high.
module rgb565_inverse_alpha_fill #(
  parameter int FB_WIDTH  = 1024,
  parameter int FB_HEIGHT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [raf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [raf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [raf_pkg::COORD_W-1:0]       in_pixel_col,
  input  wire logic [raf_pkg::COORD_W-1:0]       in_pixel_row,
  input  wire logic [raf_pkg::PIXEL_W-1:0]       in_dest_pixel,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [raf_pkg::COORD_W-1:0]       out_col,
  output logic      [raf_pkg::COORD_W-1:0]       out_row,
  output logic      [raf_pkg::PIXEL_W-1:0]       out_result_pixel,
  output logic                                   out_inside_rect
);

  localparam logic signed [13:0] FB_W_LIM = 14'(FB_WIDTH);
  localparam logic signed [13:0] FB_H_LIM = 14'(FB_HEIGHT);

  logic [7:0]                    fill_red_r;
  logic [7:0]                    fill_green_r;
  logic [7:0]                    fill_blue_r;
  logic [7:0]                    dest_weight_r;
  logic signed [raf_pkg::RECT_W-1:0] rect_left_r;
  logic signed [raf_pkg::RECT_W-1:0] rect_top_r;
  logic signed [raf_pkg::RECT_W-1:0] rect_right_r;
  logic signed [raf_pkg::RECT_W-1:0] rect_bottom_r;

  logic [4:1]          vld_r;
  logic [4:1]          en;
  raf_pkg::adv_t       adv;
  raf_pkg::pix_t       pix_r [1:4];
  raf_pkg::pix_t       pix_nxt;
  logic [7:0]          er_r;
  logic [7:0]          eg_r;
  logic [7:0]          eb_r;
  logic [4:0]          red_code;
  logic [5:0]          green_code;
  logic [4:0]          blue_code;

  logic signed [13:0]  col_s;
  logic signed [13:0]  row_s;
  logic                inside_nxt;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_red_r    <= '0;
      fill_green_r  <= '0;
      fill_blue_r   <= '0;
      dest_weight_r <= raf_pkg::DEST_WEIGHT_RESET;
      rect_left_r   <= '0;
      rect_top_r    <= '0;
      rect_right_r  <= '0;
      rect_bottom_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        raf_pkg::REG_FILL_RED:    fill_red_r    <= cfg_data[7:0];
        raf_pkg::REG_FILL_GREEN:  fill_green_r  <= cfg_data[7:0];
        raf_pkg::REG_FILL_BLUE:   fill_blue_r   <= cfg_data[7:0];
        raf_pkg::REG_DEST_WEIGHT: dest_weight_r <= cfg_data[7:0];
        raf_pkg::REG_RECT_LEFT:   rect_left_r   <= cfg_data;
        raf_pkg::REG_RECT_TOP:    rect_top_r    <= cfg_data;
        raf_pkg::REG_RECT_RIGHT:  rect_right_r  <= cfg_data;
        raf_pkg::REG_RECT_BOTTOM: rect_bottom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage loads when it is empty or the stage after it moves on.
  assign en[4]    = !vld_r[4] || !out_stall;
  assign en[3]    = !vld_r[3] || en[4];
  assign en[2]    = !vld_r[2] || en[3];
  assign en[1]    = !vld_r[1] || en[2];
  assign in_stall = !en[1];
  assign adv      = '{s2: en[2], s3: en[3], s4: en[4]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_valid;
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) vld_r[3] <= vld_r[2];
      if (en[4]) vld_r[4] <= vld_r[3];
    end
  end

  // A negative left or top edge needs no clamp since coordinates are never negative.
  assign col_s = {4'd0, in_pixel_col};
  assign row_s = {4'd0, in_pixel_row};
  assign inside_nxt = (col_s >= $signed({rect_left_r[12], rect_left_r}))
                   && (col_s <  $signed({rect_right_r[12], rect_right_r}))
                   && (col_s <  FB_W_LIM)
                   && (row_s >= $signed({rect_top_r[12], rect_top_r}))
                   && (row_s <  $signed({rect_bottom_r[12], rect_bottom_r}))
                   && (row_s <  FB_H_LIM);

  assign pix_nxt = '{col: in_pixel_col, row: in_pixel_row, px: in_dest_pixel,
                     in_rect: inside_nxt};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pix_r[1] <= pix_nxt;
      er_r     <= raf_pkg::expand5(in_dest_pixel[15:11]);
      eg_r     <= raf_pkg::expand6(in_dest_pixel[10:5]);
      eb_r     <= raf_pkg::expand5(in_dest_pixel[4:0]);
    end
    if (en[2]) pix_r[2] <= pix_r[1];
    if (en[3]) pix_r[3] <= pix_r[2];
    if (en[4]) pix_r[4] <= pix_r[3];
  end

  raf_channel #(.CHAN_W(5)) u_red (
    .clk    (clk),
    .adv    (adv),
    .e8     (er_r),
    .fill   (fill_red_r),
    .weight (dest_weight_r),
    .code   (red_code)
  );

  raf_channel #(.CHAN_W(6)) u_green (
    .clk    (clk),
    .adv    (adv),
    .e8     (eg_r),
    .fill   (fill_green_r),
    .weight (dest_weight_r),
    .code   (green_code)
  );

  raf_channel #(.CHAN_W(5)) u_blue (
    .clk    (clk),
    .adv    (adv),
    .e8     (eb_r),
    .fill   (fill_blue_r),
    .weight (dest_weight_r),
    .code   (blue_code)
  );

  assign out_valid        = vld_r[4];
  assign out_col          = pix_r[4].col;
  assign out_row          = pix_r[4].row;
  assign out_inside_rect  = pix_r[4].in_rect;
  assign out_result_pixel = pix_r[4].in_rect ? {red_code, green_code, blue_code}
                                             : pix_r[4].px;

  // The input side stalls only when every stage holds a word and the output is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld_r == 4'b1111) && out_stall)
    else $error("input stalled while the pipeline has room");

  // An accepted word always lands in the first stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[1])
    else $error("accepted word lost at the first stage");

  // Words in flight change only by what enters and what leaves.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(vld_r) == $past($countones(vld_r))
      + int'($past(in_valid && !in_stall)) - int'($past(out_valid && !out_stall)))
    else $error("pipeline word count out of balance");

endmodule

`default_nettype wire
